// File: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int CAP_W     = 5;
   localparam int IDX_MAX_W = 6;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;
   localparam logic signed [VALUE_W-1:0] PUT_VALUE  = 32'sd0;
   localparam logic signed [KEY_W-1:0]   NO_KEY     = 32'sd0;

   typedef struct packed {
      logic                      mode;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
      logic                      evicted;
      logic signed [KEY_W-1:0]   evicted_key;
   } lkvc_rsp_type;

   // Lookup outcome handed from the tag compare to the state update
   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic                 full;
      logic [IDX_MAX_W-1:0] lru_idx;
      logic [IDX_MAX_W-1:0] free_idx;
   } lkvc_pick_type;

endpackage

// File: rtl/lkvc_lookup.sv
// Parallel key compare, LRU entry select and free entry select.
module lkvc_lookup import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic [KEY_W-1:0]                   key,
   input  logic [KEY_W-1:0]                   keys     [ENTRIES],
   input  logic [ENTRIES-1:0]                 valid,
   input  logic [$clog2(ENTRIES)-1:0]         ranks    [ENTRIES],
   input  logic [$clog2(ENTRIES+1)-1:0]       count,
   input  logic [$clog2(ENTRIES+1)-1:0]       eff_cap,
   output lkvc_pick_type                      pick
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   logic [RANK_W-1:0] lru_rank;

   assign lru_rank = RANK_W'(count - CNT_W'(1));

   // Reverse scan so the lowest matching index wins
   always_comb begin
      pick      = '0;
      pick.full = (count >= eff_cap);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid[i] && (keys[i] == key)) begin
            pick.hit     = 1'b1;
            pick.hit_idx = IDX_MAX_W'(i);
         end
         if (valid[i] && (ranks[i] == lru_rank)) begin
            pick.lru_idx = IDX_MAX_W'(i);
         end
         if (!valid[i]) begin
            pick.free_idx = IDX_MAX_W'(i);
         end
      end
   end

endmodule

// File: rtl/lkvc_store.sv
// Entry storage: keys, values, valid bits, recency ranks and fill count.
module lkvc_store import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               en,
   input  logic                               mode,
   input  logic [KEY_W-1:0]                   key,
   input  logic [VALUE_W-1:0]                 value,
   input  lkvc_pick_type                      pick,
   output logic [KEY_W-1:0]                   keys     [ENTRIES],
   output logic [VALUE_W-1:0]                 values   [ENTRIES],
   output logic [ENTRIES-1:0]                 valid,
   output logic [$clog2(ENTRIES)-1:0]         ranks    [ENTRIES],
   output logic [$clog2(ENTRIES+1)-1:0]       count
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   logic [KEY_W-1:0]   key_ff   [ENTRIES];
   logic [VALUE_W-1:0] value_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff  [ENTRIES];
   logic [RANK_W-1:0]  rank_in  [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [IDX_W-1:0]   hit_idx, slot_idx, wr_idx;
   logic [RANK_W-1:0]  hit_rank;
   logic               key_we, value_we;

   assign hit_idx  = pick.hit_idx[IDX_W-1:0];
   assign slot_idx = pick.full ? pick.lru_idx[IDX_W-1:0] : pick.free_idx[IDX_W-1:0];
   assign hit_rank = rank_ff[hit_idx];

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      wr_idx   = hit_idx;
      key_we   = 1'b0;
      value_we = 1'b0;
      if (clear) begin
         valid_in = '0;
         count_in = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_in[i] = '0;
         end
      end else if (en) begin
         if (pick.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            rank_in[hit_idx] = '0;
            value_we         = (mode == MODE_PUT);
         end else if (mode == MODE_PUT) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (IDX_W'(i) != slot_idx)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            rank_in[slot_idx]  = '0;
            valid_in[slot_idx] = 1'b1;
            wr_idx             = slot_idx;
            key_we             = 1'b1;
            value_we           = 1'b1;
            if (!pick.full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[wr_idx] <= key;
      end
      if (value_we) begin
         value_ff[wr_idx] <= value;
      end
   end

   assign keys   = key_ff;
   assign values = value_ff;
   assign valid  = valid_ff;
   assign ranks  = rank_ff;
   assign count  = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above depth");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count disagrees with valid bits");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear |=> (count_ff == '0) && (valid_ff == '0))
      else $error("store not empty after clear");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (en && !clear && (mode == MODE_PUT) && !pick.hit && !pick.full)
      |=> count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
      else $error("insert without eviction did not grow count");

endmodule

// File: rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// One transaction is taken in every clock cycle: busy stays low and start may be held high
// continuously. A get or put accepted into the request register has its result on rsp_item with
// rsp_valid high once the result register has captured it; the key compare over all
// entries, the recency rank update and the result select sit between the request register
// and the result register. Results cannot be stalled. A write to the capacity register
// empties the cache in the same edge; capacity 0 acts as 1 and values above ENTRIES act as
// ENTRIES.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lkvc_req_type       req_item,
   output logic               rsp_valid,
   output lkvc_rsp_type       rsp_item,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata
);

   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int RANK_W    = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CAP_CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   lkvc_req_type       req_ff;
   logic               req_valid_ff;
   lkvc_rsp_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic [CAP_W-1:0]   capacity_ff;

   logic [CAP_CMP_W-1:0] cap_ext;
   logic [CNT_W-1:0]     eff_cap;

   logic [KEY_W-1:0]   keys   [ENTRIES];
   logic [VALUE_W-1:0] values [ENTRIES];
   logic [ENTRIES-1:0] valid;
   logic [RANK_W-1:0]  ranks  [ENTRIES];
   logic [CNT_W-1:0]   count;
   lkvc_pick_type      pick;

   assign busy = 1'b0;

   assign cap_ext = CAP_CMP_W'(capacity_ff);

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_ext > CAP_CMP_W'(ENTRIES)) begin
         eff_cap = CNT_W'(ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(16);
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   lkvc_lookup #(
      .ENTRIES (ENTRIES)
   ) u_lookup (
      .key     (req_ff.key),
      .keys    (keys),
      .valid   (valid),
      .ranks   (ranks),
      .count   (count),
      .eff_cap (eff_cap),
      .pick    (pick)
   );

   lkvc_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .clear  (csr_we),
      .en     (req_valid_ff),
      .mode   (req_ff.mode),
      .key    (req_ff.key),
      .value  (req_ff.value),
      .pick   (pick),
      .keys   (keys),
      .values (values),
      .valid  (valid),
      .ranks  (ranks),
      .count  (count)
   );

   always_comb begin
      rsp_in.hit         = pick.hit;
      rsp_in.evicted     = 1'b0;
      rsp_in.evicted_key = NO_KEY;
      if (req_ff.mode == MODE_GET) begin
         rsp_in.read_value = pick.hit ? values[pick.hit_idx[IDX_W-1:0]] : MISS_VALUE;
      end else begin
         rsp_in.read_value = PUT_VALUE;
         if (!pick.hit && pick.full) begin
            rsp_in.evicted     = 1'b1;
            rsp_in.evicted_key = keys[pick.lru_idx[IDX_W-1:0]];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_valid_ff))
      else $error("result strobe without a transaction");

   a_eviction_only_put: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.evicted) |-> (!rsp_ff.hit && $past(req_ff.mode == MODE_PUT)))
      else $error("eviction reported for a hit or a get");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !csr_we && (req_ff.mode == MODE_PUT) && !pick.hit && pick.full)
      |=> count == $past(count))
      else $error("eviction changed the entry count");

endmodule
